// ----- hdl/dlmc_pkg.sv -----
// Shared types and constants for the door lock mode controller.
package dlmc_pkg;

  localparam logic [1:0] MODE_LOCKED   = 2'd0;
  localparam logic [1:0] MODE_UNLOCKED = 2'd1;
  localparam logic [1:0] MODE_OPEN     = 2'd2;

  localparam logic [2:0] LED_LOCK   = 3'b001;
  localparam logic [2:0] LED_UNLOCK = 3'b010;
  localparam logic [2:0] LED_OPEN   = 3'b100;
  localparam logic [2:0] LED_ALL    = 3'b111;

  localparam logic [7:0] CHAR_LOWER_R = 8'h72;
  localparam logic [7:0] CHAR_LOWER_Y = 8'h79;
  localparam logic [7:0] CHAR_LOWER_G = 8'h67;
  localparam logic [7:0] CHAR_UPPER_R = 8'h52;
  localparam logic [7:0] CHAR_UPPER_Y = 8'h59;
  localparam logic [7:0] CHAR_UPPER_G = 8'h47;
  localparam logic [7:0] CHAR_UPPER_E = 8'h45;
  localparam logic [7:0] CHAR_NONE    = 8'h00;

  localparam logic CFG_TIMEOUT_LIMIT    = 1'b0;
  localparam logic CFG_LED_PULSE_PERIOD = 1'b1;

  localparam logic [15:0] TIMEOUT_LIMIT_RESET    = 16'hFFFF;
  localparam logic [7:0]  LED_PULSE_PERIOD_RESET = 8'd20;

  typedef struct packed {
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       tick;
    logic       emergency;
    logic       key_lock;
    logic       key_unlock;
    logic       key_open;
  } in_item_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       bolt;
    logic       latch_release;
    logic       led_lock;
    logic       led_unlock;
    logic       led_open;
    logic       timeout_report;
    logic       local_report_valid;
    logic [7:0] local_report_char;
  } out_item_t;

  // Outcome of the request chain for one poll cycle
  typedef struct packed {
    logic [1:0] mode;
    logic       timeout_report;
    logic       local_report_valid;
    logic [7:0] local_report_char;
  } mode_status_t;

  function automatic logic [2:0] mode_led(input logic [1:0] m);
    logic [2:0] led;
    case (m)
      MODE_LOCKED:   led = LED_LOCK;
      MODE_UNLOCKED: led = LED_UNLOCK;
      default:       led = LED_OPEN;
    endcase
    return led;
  endfunction

endpackage

// ----- hdl/dlmc_mode_logic.sv -----
// Next-state logic for the lock mode, inactivity counter and reports.
module dlmc_mode_logic import dlmc_pkg::*; #(
  parameter int COUNT_WIDTH = 16
) (
  input  in_item_t               item,
  input  logic [1:0]             mode,
  input  logic [COUNT_WIDTH-1:0] idle_count,
  input  logic [15:0]            timeout_limit,
  output mode_status_t           status,
  output logic [COUNT_WIDTH-1:0] idle_count_next
);

  localparam int CW = (COUNT_WIDTH + 1 > 17) ? COUNT_WIDTH + 1 : 17;

  logic             cmd_hit;
  logic [1:0]       cmd_mode;
  logic [1:0]       mode_cmd;
  logic [CW-1:0]    idle_inc;
  logic             timeout_hit;
  logic [1:0]       mode_tmo;
  logic             local_hit;
  logic [1:0]       local_mode;
  logic [7:0]       local_char;

  always_comb begin
    cmd_hit  = 1'b0;
    cmd_mode = MODE_LOCKED;
    if (item.rx_valid) begin
      case (item.rx_byte)
        CHAR_LOWER_R: begin
          cmd_hit  = 1'b1;
          cmd_mode = MODE_LOCKED;
        end
        CHAR_LOWER_Y: begin
          cmd_hit  = 1'b1;
          cmd_mode = MODE_UNLOCKED;
        end
        CHAR_LOWER_G: begin
          cmd_hit  = 1'b1;
          cmd_mode = MODE_OPEN;
        end
        default: cmd_hit = 1'b0;
      endcase
    end
  end

  assign mode_cmd = cmd_hit ? cmd_mode : mode;

  // A valid command clears the counter before the tick is counted
  assign idle_inc = (cmd_hit ? CW'(0) : CW'(idle_count)) + CW'(1);
  assign timeout_hit = item.tick &&
                       ((idle_inc >= CW'(timeout_limit)) || idle_inc[COUNT_WIDTH]);
  assign mode_tmo = timeout_hit ? MODE_LOCKED : mode_cmd;

  // Emergency first, then keys green, yellow, red
  always_comb begin
    local_hit  = 1'b1;
    local_mode = MODE_OPEN;
    local_char = CHAR_UPPER_E;
    if (item.emergency) begin
      local_mode = MODE_OPEN;
      local_char = CHAR_UPPER_E;
    end else if (item.key_open) begin
      local_mode = MODE_OPEN;
      local_char = CHAR_UPPER_G;
    end else if (item.key_unlock) begin
      local_mode = MODE_UNLOCKED;
      local_char = CHAR_UPPER_Y;
    end else if (item.key_lock) begin
      local_mode = MODE_LOCKED;
      local_char = CHAR_UPPER_R;
    end else begin
      local_hit = 1'b0;
    end
  end

  always_comb begin
    status.timeout_report     = timeout_hit && (mode_cmd != MODE_LOCKED);
    status.local_report_valid = local_hit && (local_mode != mode_tmo);
    status.local_report_char  = status.local_report_valid ? local_char : CHAR_NONE;
    status.mode               = local_hit ? local_mode : mode_tmo;
    if (local_hit || timeout_hit) begin
      idle_count_next = '0;
    end else if (item.tick) begin
      idle_count_next = idle_inc[COUNT_WIDTH-1:0];
    end else if (cmd_hit) begin
      idle_count_next = '0;
    end else begin
      idle_count_next = idle_count;
    end
  end

endmodule

// ----- hdl/dlmc_led_pulse.sv -----
// LED levels and pulse counter for one poll cycle.
module dlmc_led_pulse import dlmc_pkg::*; (
  input  logic [1:0] mode,
  input  logic [7:0] pulse_count,
  input  logic [2:0] led_levels,
  input  logic [7:0] led_pulse_period,
  output logic [7:0] pulse_count_next,
  output logic [2:0] led_levels_next
);

  logic [8:0] pulse_inc;
  logic [2:0] own;
  logic [2:0] others;

  assign pulse_inc        = {1'b0, pulse_count} + 9'd1;
  assign pulse_count_next = (pulse_inc >= {1'b0, led_pulse_period}) ? 8'd0 : pulse_inc[7:0];
  assign own              = mode_led(mode);
  assign others           = LED_ALL & ~own;

  // On a pulse cycle toggle the other two LEDs
  assign led_levels_next = (pulse_count_next != 8'd0) ? own
                         : ((~led_levels & others) | own);

endmodule

// ----- hdl/door_lock_mode_controller_top.sv -----
// Door lock mode controller: input register, poll-cycle logic and result register.
// The input register takes the item; the result register then loads its poll-cycle result.
// Throughput: one item per cycle; both stages advance together unless the result stalls.
// Reset (rst, synchronous): mode locked, LEDs off, counters cleared,
// timeout_limit 65535, led_pulse_period 20, both stages empty.
module door_lock_mode_controller_top import dlmc_pkg::*; #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic                   advance;
  logic                   item_valid;
  in_item_t               item;
  logic [15:0]            timeout_limit;
  logic [7:0]             led_pulse_period;
  logic [1:0]             lock_mode;
  logic [COUNT_WIDTH-1:0] idle_count;
  logic [COUNT_WIDTH-1:0] idle_count_next;
  logic [7:0]             pulse_count;
  logic [7:0]             pulse_count_next;
  logic [2:0]             led_levels;
  logic [2:0]             led_levels_next;
  mode_status_t           status;

  assign advance   = !(out_valid && out_stall);
  assign in_stall  = !advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_limit    <= TIMEOUT_LIMIT_RESET;
      led_pulse_period <= LED_PULSE_PERIOD_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TIMEOUT_LIMIT:    timeout_limit    <= cfg_data;
        CFG_LED_PULSE_PERIOD: led_pulse_period <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (advance) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      item <= in_data;
    end
  end

  dlmc_mode_logic #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_mode (
    .item            (item),
    .mode            (lock_mode),
    .idle_count      (idle_count),
    .timeout_limit   (timeout_limit),
    .status          (status),
    .idle_count_next (idle_count_next)
  );

  dlmc_led_pulse u_led (
    .mode             (status.mode),
    .pulse_count      (pulse_count),
    .led_levels       (led_levels),
    .led_pulse_period (led_pulse_period),
    .pulse_count_next (pulse_count_next),
    .led_levels_next  (led_levels_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      lock_mode   <= MODE_LOCKED;
      idle_count  <= '0;
      pulse_count <= 8'd0;
      led_levels  <= 3'b000;
      out_valid   <= 1'b0;
    end else if (advance) begin
      out_valid <= item_valid;
      if (item_valid) begin
        lock_mode   <= status.mode;
        idle_count  <= idle_count_next;
        pulse_count <= pulse_count_next;
        led_levels  <= led_levels_next;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (advance && item_valid) begin
      out_data.mode               <= status.mode;
      out_data.bolt               <= (status.mode == MODE_LOCKED);
      out_data.latch_release      <= (status.mode == MODE_OPEN);
      out_data.led_lock           <= led_levels_next[0];
      out_data.led_unlock         <= led_levels_next[1];
      out_data.led_open           <= led_levels_next[2];
      out_data.timeout_report     <= status.timeout_report;
      out_data.local_report_valid <= status.local_report_valid;
      out_data.local_report_char  <= status.local_report_char;
    end
  end

  a_bolt_follows_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.bolt == (out_data.mode == MODE_LOCKED)) &&
                  (out_data.latch_release == (out_data.mode == MODE_OPEN)))
    else $error("actuator drive does not follow mode");

  a_mode_code: assert property (@(posedge clk) disable iff (rst)
    lock_mode != 2'd3)
    else $error("lock mode holds an unused code");

  a_timeout_locks: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.timeout_report && !out_data.local_report_valid) |->
    out_data.mode == MODE_LOCKED)
    else $error("timeout report without locked mode");

  a_mode_led_lit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({out_data.led_open, out_data.led_unlock, out_data.led_lock} &
                   mode_led(out_data.mode)) != 3'b000)
    else $error("LED of the current mode is not lit");

  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(lock_mode) && $stable(pulse_count))
    else $error("state advanced while the result stalled");

endmodule
